// ----- src/hhf_pkg.sv -----
// Shared types, sizes and helpers for the height-map hole filler.
// Used by every module of the block; it depends on nothing else.
`default_nettype none

package hhf_pkg;

    // Image store geometry.
    localparam int MAX_COLS    = 32;
    localparam int MAX_ROWS    = 32;
    localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int X_W         = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int Y_W         = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    // Field and register widths.
    localparam int PIX_W      = 8;
    localparam int SIZE_W     = 6;
    localparam int PASS_W     = 4;
    localparam int NEED_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // Coordinate compares run at a width that holds any coordinate plus one.
    localparam int XY_MAX_W = (X_W > Y_W) ? X_W : Y_W;
    localparam int CRD_W    = ((XY_MAX_W > SIZE_W) ? XY_MAX_W : SIZE_W) + 1;

    // Neighbor accumulation: up to eight known neighbors of at most 254 each.
    localparam int NCNT_W = 4;
    localparam int SUM_W  = 11;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    localparam logic [PIX_W-1:0] UNKNOWN_PIXEL = 8'hFF;

    // Item kinds carried in tuser.
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_COLS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PASSES    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_KNOWN = 2'd3;

    // Register reset values.
    localparam logic [SIZE_W-1:0] COLS_RESET      = 6'd20;
    localparam logic [SIZE_W-1:0] ROWS_RESET      = 6'd20;
    localparam logic [PASS_W-1:0] PASSES_RESET    = 4'd3;
    localparam logic [NEED_W-1:0] MIN_KNOWN_RESET = 4'd4;

    typedef struct packed {
        logic [SIZE_W-1:0] cols;
        logic [SIZE_W-1:0] rows;
        logic [PASS_W-1:0] passes;
        logic [NEED_W-1:0] min_known;
    } cfg_t;

    // One classified item as handed from the front to the back.
    typedef struct packed {
        logic              is_read;
        logic              wr_en;
        logic              start_fill;
        logic              final_px;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
    } cmd_t;

    // Image sizes of zero act as one; sizes above the store saturate.
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input int top);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (int'(v) > top)
            r = SIZE_W'(top);
        else
            r = v;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/hhf_queue.sv -----
// Short command queue that decouples the item front from the store back.
// Depends on hhf_pkg for the command type and depth.
`default_nettype none

module hhf_queue
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire hhf_pkg::cmd_t push_cmd,
    output logic              full,
    input  wire logic         pop,
    output logic              head_valid,
    output hhf_pkg::cmd_t     head_cmd
);

    localparam int PTR_W = $clog2(hhf_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(hhf_pkg::QUEUE_DEPTH + 1);

    hhf_pkg::cmd_t    slot_reg [hhf_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    // Status toward both sides.
    assign full       = (count_reg == CNT_W'(hhf_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count update.
    always_comb
    begin
        wptr_next  = do_push ? wptr_reg + PTR_W'(1) : wptr_reg;
        rptr_next  = do_pop ? rptr_reg + PTR_W'(1) : rptr_reg;
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

// ----- src/hhf_front.sv -----
// Front part: takes input transactions and configuration writes, keeps the
// load and read pointers, and turns each item into a store command.
// Depends on hhf_pkg.
`default_nettype none

module hhf_front
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [hhf_pkg::PIX_W-1:0]        s_tdata,
    input  wire logic                             s_tlast,
    input  wire logic                             s_tuser,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [hhf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [hhf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             q_full,
    output logic                                  q_push,
    output hhf_pkg::cmd_t                         q_cmd,
    output hhf_pkg::cfg_t                         cfg
);

    hhf_pkg::cfg_t                      cfg_reg, cfg_next;
    logic [hhf_pkg::CNT_W-1:0]          load_ptr_reg, load_ptr_next;
    logic [hhf_pkg::ADDR_W-1:0]         read_ptr_reg, read_ptr_next;
    logic                               filled_reg, filled_next;
    logic [hhf_pkg::SIZE_W-1:0]         cols_c;
    logic [hhf_pkg::SIZE_W-1:0]         rows_c;
    logic [2*hhf_pkg::SIZE_W-1:0]       prod;
    logic [hhf_pkg::CNT_W-1:0]          total;
    logic                               accept;

    assign s_tready  = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign cfg       = cfg_reg;

    // Image size in pixels from the clamped sizes.
    assign cols_c = hhf_pkg::clamp_size(cfg_reg.cols, hhf_pkg::MAX_COLS);
    assign rows_c = hhf_pkg::clamp_size(cfg_reg.rows, hhf_pkg::MAX_ROWS);
    assign prod   = {{hhf_pkg::SIZE_W{1'b0}}, cols_c} * {{hhf_pkg::SIZE_W{1'b0}}, rows_c};
    assign total  = hhf_pkg::CNT_W'(prod);

    // Configuration register writes, masked to each register's width.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hhf_pkg::CFG_COLS:      cfg_next.cols      = cfg_data[hhf_pkg::SIZE_W-1:0];
                hhf_pkg::CFG_ROWS:      cfg_next.rows      = cfg_data[hhf_pkg::SIZE_W-1:0];
                hhf_pkg::CFG_PASSES:    cfg_next.passes    = cfg_data[hhf_pkg::PASS_W-1:0];
                hhf_pkg::CFG_MIN_KNOWN: cfg_next.min_known = cfg_data[hhf_pkg::NEED_W-1:0];
                default:                cfg_next           = cfg_reg;
            endcase
        end
    end

    // Item classification and pointer bookkeeping.
    always_comb
    begin
        load_ptr_next = load_ptr_reg;
        read_ptr_next = read_ptr_reg;
        filled_next   = filled_reg;
        q_push        = 1'b0;
        q_cmd         = '0;
        q_cmd.data    = s_tdata;
        if (accept)
        begin
            if (s_tuser == hhf_pkg::KIND_LOAD)
            begin
                // A load drops any image that was ready for readout.
                filled_next   = 1'b0;
                read_ptr_next = '0;
                if (load_ptr_reg < total)
                begin
                    q_cmd.wr_en   = 1'b1;
                    q_cmd.addr    = load_ptr_reg[hhf_pkg::ADDR_W-1:0];
                    load_ptr_next = load_ptr_reg + hhf_pkg::CNT_W'(1);
                end
                if (s_tlast)
                begin
                    q_cmd.start_fill = 1'b1;
                    load_ptr_next    = '0;
                    filled_next      = 1'b1;
                end
                q_push = q_cmd.wr_en || q_cmd.start_fill;
            end
            else if (filled_reg)
            begin
                q_push         = 1'b1;
                q_cmd.is_read  = 1'b1;
                q_cmd.addr     = read_ptr_reg;
                q_cmd.final_px = (hhf_pkg::CNT_W'(read_ptr_reg) + hhf_pkg::CNT_W'(1)) >= total;
                if (q_cmd.final_px)
                begin
                    read_ptr_next = '0;
                    filled_next   = 1'b0;
                end
                else
                begin
                    read_ptr_next = read_ptr_reg + hhf_pkg::ADDR_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cols      <= hhf_pkg::COLS_RESET;
            cfg_reg.rows      <= hhf_pkg::ROWS_RESET;
            cfg_reg.passes    <= hhf_pkg::PASSES_RESET;
            cfg_reg.min_known <= hhf_pkg::MIN_KNOWN_RESET;
            load_ptr_reg      <= '0;
            read_ptr_reg      <= '0;
            filled_reg        <= 1'b0;
        end
        else
        begin
            cfg_reg      <= cfg_next;
            load_ptr_reg <= load_ptr_next;
            read_ptr_reg <= read_ptr_next;
            filled_reg   <= filled_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/hhf_div.sv -----
// Restoring divider for the neighbor mean: one quotient bit per cycle.
// Depends on hhf_pkg for the sum, count and pixel widths.
`default_nettype none

module hhf_div
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [hhf_pkg::SUM_W-1:0]      dividend,
    input  wire logic [hhf_pkg::NCNT_W-1:0]     divisor,
    output logic                                done,
    output logic [hhf_pkg::PIX_W-1:0]           quotient
);

    localparam int STEP_W = $clog2(hhf_pkg::SUM_W);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [STEP_W-1:0]              step_reg, step_next;
    logic [hhf_pkg::NCNT_W-1:0]     rem_reg, rem_next;
    logic [hhf_pkg::SUM_W-1:0]      quo_reg, quo_next;
    logic [hhf_pkg::NCNT_W-1:0]     dvs_reg, dvs_next;
    logic [hhf_pkg::NCNT_W:0]       trial;
    logic [hhf_pkg::NCNT_W:0]       diff;
    logic                           ge;

    assign done     = done_reg;
    assign quotient = quo_reg[hhf_pkg::PIX_W-1:0];

    // One shift-and-subtract step.
    assign trial = {rem_reg, quo_reg[hhf_pkg::SUM_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[hhf_pkg::NCNT_W-1:0] : trial[hhf_pkg::NCNT_W-1:0];
            quo_next  = {quo_reg[hhf_pkg::SUM_W-2:0], ge};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(hhf_pkg::SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

endmodule

`default_nettype wire

// ----- src/hhf_back.sv -----
// Back part: owns the image store, carries out load writes and readouts,
// runs the fill passes and buffers results for the master side.
// Depends on hhf_pkg; works with hhf_div for the neighbor mean.
`default_nettype none

module hhf_back
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire hhf_pkg::cfg_t                  cfg,
    input  wire logic                           q_valid,
    input  wire hhf_pkg::cmd_t                  q_cmd,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [hhf_pkg::PIX_W-1:0]           m_tdata,
    output logic                                m_tlast,
    output logic                                div_start,
    output logic [hhf_pkg::SUM_W-1:0]           div_dividend,
    output logic [hhf_pkg::NCNT_W-1:0]          div_divisor,
    input  wire logic                           div_done,
    input  wire logic [hhf_pkg::PIX_W-1:0]      div_quo
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CENTER = 3'd1;
    localparam logic [2:0] ST_CWAIT  = 3'd2;
    localparam logic [2:0] ST_NBR    = 3'd3;
    localparam logic [2:0] ST_NLAST  = 3'd4;
    localparam logic [2:0] ST_DECIDE = 3'd5;
    localparam logic [2:0] ST_DIV    = 3'd6;

    localparam int PASS_CW = hhf_pkg::PASS_W + 1;
    localparam int CRD_W   = hhf_pkg::CRD_W;

    logic [hhf_pkg::PIX_W-1:0]      mem [hhf_pkg::STORE_DEPTH];
    logic [hhf_pkg::PIX_W-1:0]      rdata_reg;

    logic [2:0]                     state_reg, state_next;
    logic [hhf_pkg::X_W-1:0]        x_reg, x_next;
    logic [hhf_pkg::Y_W-1:0]        y_reg, y_next;
    logic [hhf_pkg::ADDR_W-1:0]     here_reg, here_next;
    logic [hhf_pkg::PASS_W-1:0]     pass_reg, pass_next;
    logic [2:0]                     k_reg, k_next;
    logic [hhf_pkg::SUM_W-1:0]      sum_reg, sum_next;
    logic [hhf_pkg::NCNT_W-1:0]     kcnt_reg, kcnt_next;
    logic                           acc_pend_reg, acc_pend_next;
    logic                           rd_pend_reg, rd_pend_next;
    logic                           rd_last_reg, rd_last_next;

    logic                           mem_we;
    logic [hhf_pkg::ADDR_W-1:0]     mem_waddr;
    logic [hhf_pkg::PIX_W-1:0]      mem_wdata;
    logic                           mem_re;
    logic [hhf_pkg::ADDR_W-1:0]     mem_raddr;

    logic [hhf_pkg::SIZE_W-1:0]     cols_c;
    logic [hhf_pkg::SIZE_W-1:0]     rows_c;
    logic [hhf_pkg::NEED_W-1:0]     need;
    logic                           advance;
    logic                           x_lo, x_hi, y_lo, y_hi;
    logic [hhf_pkg::ADDR_W-1:0]     col_off;
    logic                           nb_ok;
    logic [hhf_pkg::ADDR_W-1:0]     nb_addr;

    // Two-entry result buffer.
    logic [hhf_pkg::PIX_W-1:0]      of_data_reg [2];
    logic                           of_last_reg [2];
    logic                           of_wptr_reg;
    logic                           of_rptr_reg;
    logic [1:0]                     of_cnt_reg;
    logic                           pop_out;
    logic [2:0]                     occ;
    logic                           read_room;

    assign cols_c = hhf_pkg::clamp_size(cfg.cols, hhf_pkg::MAX_COLS);
    assign rows_c = hhf_pkg::clamp_size(cfg.rows, hhf_pkg::MAX_ROWS);
    assign need   = (cfg.min_known == '0) ? hhf_pkg::NEED_W'(1) : cfg.min_known;

    assign div_dividend = sum_reg;
    assign div_divisor  = kcnt_reg;

    // Result buffer status; a readout issues only if its slot is assured.
    assign m_tvalid  = (of_cnt_reg != 2'd0);
    assign m_tdata   = of_data_reg[of_rptr_reg];
    assign m_tlast   = of_last_reg[of_rptr_reg];
    assign pop_out   = m_tvalid && m_tready;
    assign occ       = {1'b0, of_cnt_reg} + {2'b0, rd_pend_reg};
    assign read_room = occ <= (3'd1 + {2'b0, pop_out});

    // Bounds of the current pixel's neighborhood.
    assign x_lo    = (x_reg != '0);
    assign x_hi    = (CRD_W'(x_reg) + CRD_W'(1)) < CRD_W'(cols_c);
    assign y_lo    = (y_reg != '0);
    assign y_hi    = (CRD_W'(y_reg) + CRD_W'(1)) < CRD_W'(rows_c);
    assign col_off = hhf_pkg::ADDR_W'(rows_c);

    // Neighbor address for the current step, column-major layout.
    always_comb
    begin
        case (k_reg)
            3'd0:
            begin
                nb_ok   = x_lo && y_lo;
                nb_addr = here_reg - col_off - hhf_pkg::ADDR_W'(1);
            end
            3'd1:
            begin
                nb_ok   = x_lo;
                nb_addr = here_reg - col_off;
            end
            3'd2:
            begin
                nb_ok   = x_lo && y_hi;
                nb_addr = here_reg - col_off + hhf_pkg::ADDR_W'(1);
            end
            3'd3:
            begin
                nb_ok   = y_lo;
                nb_addr = here_reg - hhf_pkg::ADDR_W'(1);
            end
            3'd4:
            begin
                nb_ok   = y_hi;
                nb_addr = here_reg + hhf_pkg::ADDR_W'(1);
            end
            3'd5:
            begin
                nb_ok   = x_hi && y_lo;
                nb_addr = here_reg + col_off - hhf_pkg::ADDR_W'(1);
            end
            3'd6:
            begin
                nb_ok   = x_hi;
                nb_addr = here_reg + col_off;
            end
            default:
            begin
                nb_ok   = x_hi && y_hi;
                nb_addr = here_reg + col_off + hhf_pkg::ADDR_W'(1);
            end
        endcase
    end

    // Command execution and fill sequencer.
    always_comb
    begin
        state_next    = state_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        here_next     = here_reg;
        pass_next     = pass_reg;
        k_next        = k_reg;
        sum_next      = sum_reg;
        kcnt_next     = kcnt_reg;
        acc_pend_next = 1'b0;
        rd_pend_next  = 1'b0;
        rd_last_next  = rd_last_reg;
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = q_cmd.addr;
        mem_wdata     = q_cmd.data;
        mem_re        = 1'b0;
        mem_raddr     = q_cmd.addr;
        div_start     = 1'b0;
        advance       = 1'b0;

        // Known neighbors add into the running sum in the cycle after their read.
        if (acc_pend_reg && (rdata_reg != hhf_pkg::UNKNOWN_PIXEL))
        begin
            sum_next  = sum_reg + hhf_pkg::SUM_W'(rdata_reg);
            kcnt_next = kcnt_reg + hhf_pkg::NCNT_W'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_cmd.is_read)
                    begin
                        if (read_room)
                        begin
                            q_pop        = 1'b1;
                            mem_re       = 1'b1;
                            rd_pend_next = 1'b1;
                            rd_last_next = q_cmd.final_px;
                        end
                    end
                    else
                    begin
                        q_pop  = 1'b1;
                        mem_we = q_cmd.wr_en;
                        if (q_cmd.start_fill && (cfg.passes != '0))
                        begin
                            x_next     = '0;
                            y_next     = '0;
                            here_next  = '0;
                            pass_next  = '0;
                            state_next = ST_CENTER;
                        end
                    end
                end
            end
            ST_CENTER:
            begin
                mem_re     = 1'b1;
                mem_raddr  = here_reg;
                state_next = ST_CWAIT;
            end
            ST_CWAIT:
            begin
                if (rdata_reg == hhf_pkg::UNKNOWN_PIXEL)
                begin
                    sum_next   = '0;
                    kcnt_next  = '0;
                    k_next     = '0;
                    state_next = ST_NBR;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            ST_NBR:
            begin
                mem_raddr     = nb_addr;
                mem_re        = nb_ok;
                acc_pend_next = nb_ok;
                k_next        = k_reg + 3'd1;
                if (k_reg == 3'd7)
                    state_next = ST_NLAST;
            end
            ST_NLAST:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (kcnt_reg >= need)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = here_reg;
                    mem_wdata = div_quo;
                    advance   = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Step to the next pixel in load order, then the next pass.
        if (advance)
        begin
            here_next  = here_reg + hhf_pkg::ADDR_W'(1);
            state_next = ST_CENTER;
            if (y_hi)
            begin
                y_next = y_reg + hhf_pkg::Y_W'(1);
            end
            else if (x_hi)
            begin
                y_next = '0;
                x_next = x_reg + hhf_pkg::X_W'(1);
            end
            else if ((PASS_CW'(pass_reg) + PASS_CW'(1)) < PASS_CW'(cfg.passes))
            begin
                y_next    = '0;
                x_next    = '0;
                here_next = '0;
                pass_next = pass_reg + hhf_pkg::PASS_W'(1);
            end
            else
            begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            acc_pend_reg <= 1'b0;
            rd_pend_reg  <= 1'b0;
            of_wptr_reg  <= 1'b0;
            of_rptr_reg  <= 1'b0;
            of_cnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg    <= state_next;
            acc_pend_reg <= acc_pend_next;
            rd_pend_reg  <= rd_pend_next;
            if (rd_pend_reg)
                of_wptr_reg <= !of_wptr_reg;
            if (pop_out)
                of_rptr_reg <= !of_rptr_reg;
            of_cnt_reg <= of_cnt_reg + {1'b0, rd_pend_reg} - {1'b0, pop_out};
        end
    end

    // Sequencer working registers.
    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        here_reg    <= here_next;
        pass_reg    <= pass_next;
        k_reg       <= k_next;
        sum_reg     <= sum_next;
        kcnt_reg    <= kcnt_next;
        rd_last_reg <= rd_last_next;
        if (rd_pend_reg)
        begin
            of_data_reg[of_wptr_reg] <= rdata_reg;
            of_last_reg[of_wptr_reg] <= rd_last_reg;
        end
    end

    // Image store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

endmodule

`default_nettype wire

// ----- src/heightmap_hole_fill.sv -----
// A read transaction's pixel passes through the command queue, the registered store
// read and the result buffer before it is offered on the master side.
// Throughput: loads and reads stream one per cycle while no fill runs and the master
// side takes results; the four-entry command queue and two-entry result buffer let
// each side stall on its own. The last load starts the fill: per pass, known pixels
// are skipped; unknown ones with enough known neighbors get the 11-step divider mean.
// Reset (rst_n, asynchronous) clears pointers, queue and result buffer and sets the
// configuration registers to their reset values; the store is not cleared.
`default_nettype none

module heightmap_hole_fill
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,   // [7:0] pixel_value
    input  wire logic                               s_tlast,
    input  wire logic                               s_tuser,   // [0] kind
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [7:0]                              m_tdata,   // [7:0] pixel_out
    output logic                                    m_tlast,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [hhf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [hhf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    hhf_pkg::cfg_t                      cfg;
    hhf_pkg::cmd_t                      push_cmd;
    hhf_pkg::cmd_t                      head_cmd;
    logic                               q_push;
    logic                               q_full;
    logic                               q_pop;
    logic                               q_valid;
    logic                               div_start;
    logic                               div_done;
    logic [hhf_pkg::SUM_W-1:0]          div_dividend;
    logic [hhf_pkg::NCNT_W-1:0]         div_divisor;
    logic [hhf_pkg::PIX_W-1:0]          div_quo;

    // Item intake and classification.
    hhf_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd),
        .cfg       (cfg)
    );

    // Command queue.
    hhf_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (head_cmd)
    );

    // Mean divider for filled pixels.
    hhf_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Store, fill passes and result buffer.
    hhf_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_valid      (q_valid),
        .q_cmd        (head_cmd),
        .q_pop        (q_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_done     (div_done),
        .div_quo      (div_quo)
    );

endmodule

`default_nettype wire

// ----- src/hhf_checker.sv -----
// Port-level checks for the height-map hole filler, bound to the top level.
// Depends only on the handshake and result ports of heightmap_hole_fill.
`default_nettype none

module hhf_checker
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    input  wire logic                               s_tready,
    input  wire logic                               m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic [7:0]                         m_tdata,
    input  wire logic                               m_tlast,
    input  wire logic                               cfg_ready
);

    // No result is offered while reset is applied.
    a_no_result_in_reset: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result offered during reset");

    // Leaving reset, both the item and the configuration side are open.
    a_ready_after_reset: assert property (@(posedge clk) $rose(rst_n) |-> s_tready && cfg_ready)
        else $error("not ready after reset");

    // The intake can only fill up through an accepted transaction.
    a_ready_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready && !s_tvalid |=> s_tready)
        else $error("intake closed without a transaction");

    // A stalled result holds its payload.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind heightmap_hole_fill hhf_checker u_checker (.*);

`default_nettype wire
